// ===== rtl/haversine_distance_unit_macros.svh =====
// Assertion macros used by the checker of the haversine distance unit.
`ifndef HAVERSINE_DISTANCE_UNIT_MACROS_SVH
`define HAVERSINE_DISTANCE_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define HDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("haversine checker: next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define HDU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("haversine checker: same-cycle property failed");

// Consequent must hold in the cycle after reset is seen.
`define HDU_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("haversine checker: reset property failed");

`endif

// ===== rtl/hdu_pkg.sv =====
`timescale 1ns / 1ps
package hdu_pkg;

  // Q1.30 unity and angle constants (angles in half-units of 1e-7 degree)
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [32:0] TURN_HALF  = 33'd7200000000;
  localparam logic [32:0] QUART_HALF = 33'd1800000000;
  localparam logic [32:0] HALF_HALF  = 33'd3600000000;
  localparam logic [32:0] TQUART_HALF = 33'd5400000000;
  localparam logic [32:0] OCT_HALF   = 33'd900000000;
  localparam logic [31:0] RAD_K      = 32'd4024455254;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  localparam logic [30:0] QTRPI_Q30  = 31'd843314857;
  localparam logic [29:0] RADIUS_CM  = 30'd637100000;

  // Polynomial pipeline: one x^2 stage, two stages per Horner step, one final stage
  localparam int POLY_STEPS = 6;
  localparam int POLY_CARRY = 2 * POLY_STEPS + 1;
  localparam int POLY_LAT   = 2 * POLY_STEPS + 2;

  localparam int SQRT_STEPS = 31;
  localparam int ASIN_BITS  = 31;
  localparam int BIT_LAT    = POLY_LAT + 2;
  localparam int PIPE_DEPTH = 3 + POLY_LAT + 3 + SQRT_STEPS + ASIN_BITS * BIT_LAT;

  typedef logic [32:0] rcp_t;
  typedef logic [5:0]  shamt_t;

  // floor(q / d) = (q * ceil(2^s / d)) >> s, exact for q < 2^31 with s = 31 + ceil(log2 d).
  // The sine series has one step fewer; its first step multiplies by zero and keeps unity.
  localparam rcp_t SIN_RCP [POLY_STEPS] = '{
    33'd0,
    33'(((64'd1 << 38) + 64'd109) / 64'd110),
    33'(((64'd1 << 38) + 64'd71) / 64'd72),
    33'(((64'd1 << 37) + 64'd41) / 64'd42),
    33'(((64'd1 << 36) + 64'd19) / 64'd20),
    33'(((64'd1 << 34) + 64'd5) / 64'd6)
  };
  localparam shamt_t SIN_SH [POLY_STEPS] = '{6'd0, 6'd38, 6'd38, 6'd37, 6'd36, 6'd34};

  localparam rcp_t COS_RCP [POLY_STEPS] = '{
    33'(((64'd1 << 39) + 64'd131) / 64'd132),
    33'(((64'd1 << 38) + 64'd89) / 64'd90),
    33'(((64'd1 << 37) + 64'd55) / 64'd56),
    33'(((64'd1 << 36) + 64'd29) / 64'd30),
    33'(((64'd1 << 35) + 64'd11) / 64'd12),
    33'(((64'd1 << 32) + 64'd1) / 64'd2)
  };
  localparam shamt_t COS_SH [POLY_STEPS] = '{6'd39, 6'd38, 6'd37, 6'd36, 6'd35, 6'd32};

endpackage

// ===== rtl/hdu_in_if.sv =====
`timescale 1ns / 1ps
interface hdu_in_if ();
  logic               valid;
  logic               ready;
  logic signed [30:0] first_lat;
  logic signed [31:0] first_lon;
  logic signed [30:0] second_lat;
  logic signed [31:0] second_lon;

  modport source (output valid, output first_lat, output first_lon,
                  output second_lat, output second_lon, input ready);
  modport sink   (input valid, input first_lat, input first_lon,
                  input second_lat, input second_lon, output ready);
endinterface

// ===== rtl/hdu_out_if.sv =====
`timescale 1ns / 1ps
interface hdu_out_if ();
  logic        valid;
  logic        ready;
  logic [30:0] distance_cm;

  modport source (output valid, output distance_cm, input ready);
  modport sink   (input valid, input distance_cm, output ready);
endinterface

// ===== rtl/hdu_poly.sv =====
`timescale 1ns / 1ps
module hdu_poly import hdu_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [29:0] x,
  input  logic        sel_cos,
  output logic [30:0] res
);

  logic [29:0] x_r    [POLY_CARRY];
  logic        cos_r  [POLY_CARRY];
  logic [29:0] x2_r   [POLY_CARRY];
  logic [30:0] prod_r [POLY_STEPS];
  logic [30:0] t_r    [POLY_STEPS];
  logic [30:0] res_r;
  logic [59:0] sq;
  logic [60:0] fin_p;

  assign sq = x * x;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= x;
      cos_r[0] <= sel_cos;
      x2_r[0]  <= sq[59:30];
      for (int k = 1; k < POLY_CARRY; k++) begin
        x_r[k]   <= x_r[k-1];
        cos_r[k] <= cos_r[k-1];
        x2_r[k]  <= x2_r[k-1];
      end
    end
  end

  // Horner step: t = 1 - floor(floor(x2 * t) / d)
  for (genvar i = 0; i < POLY_STEPS; i++) begin : g_step
    logic [30:0] t_in;
    logic [60:0] p;
    rcp_t        m;
    shamt_t      sh;
    logic [63:0] q;
    logic [30:0] quo;

    if (i == 0) begin : g_first
      assign t_in = ONE_Q30;
    end else begin : g_next
      assign t_in = t_r[i-1];
    end

    assign p   = x2_r[2*i] * t_in;
    assign m   = cos_r[2*i+1] ? COS_RCP[i] : SIN_RCP[i];
    assign sh  = cos_r[2*i+1] ? COS_SH[i] : SIN_SH[i];
    assign q   = prod_r[i] * m;
    assign quo = 31'(q >> sh);

    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[i] <= 31'(p >> 30);
        t_r[i]    <= ONE_Q30 - quo;
      end
    end
  end

  assign fin_p = x_r[POLY_CARRY-1] * t_r[POLY_STEPS-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= cos_r[POLY_CARRY-1] ? t_r[POLY_STEPS-1] : 31'(fin_p >> 30);
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/hdu_asin_bit.sv =====
`timescale 1ns / 1ps
module hdu_asin_bit import hdu_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [30:0] bit_mask,
  input  logic [30:0] th_in,
  input  logic [30:0] h_in,
  output logic [30:0] th_out,
  output logic [30:0] h_out
);

  logic [30:0] cand;
  logic [30:0] arg_full;
  logic        use_cos;
  logic [29:0] arg_r;
  logic        cos_r;
  logic [30:0] cand_r;
  logic [30:0] th_r;
  logic [30:0] h_r;
  logic        ok_r;
  logic [30:0] cand_d [POLY_LAT];
  logic [30:0] th_d   [POLY_LAT];
  logic [30:0] h_d    [POLY_LAT];
  logic        ok_d   [POLY_LAT];
  logic [30:0] sin_val;
  logic [30:0] th_out_r;
  logic [30:0] h_out_r;

  // Above pi/4 take the cosine series of the complement
  assign cand     = th_in | bit_mask;
  assign use_cos  = cand > QTRPI_Q30;
  assign arg_full = HALFPI_Q30 - cand;

  always_ff @(posedge clk) begin
    if (adv) begin
      arg_r  <= use_cos ? arg_full[29:0] : cand[29:0];
      cos_r  <= use_cos;
      cand_r <= cand;
      th_r   <= th_in;
      h_r    <= h_in;
      ok_r   <= cand <= HALFPI_Q30;
    end
  end

  hdu_poly u_poly (
    .clk     (clk),
    .adv     (adv),
    .x       (arg_r),
    .sel_cos (cos_r),
    .res     (sin_val)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      cand_d[0] <= cand_r;
      th_d[0]   <= th_r;
      h_d[0]    <= h_r;
      ok_d[0]   <= ok_r;
      for (int k = 1; k < POLY_LAT; k++) begin
        cand_d[k] <= cand_d[k-1];
        th_d[k]   <= th_d[k-1];
        h_d[k]    <= h_d[k-1];
        ok_d[k]   <= ok_d[k-1];
      end
      th_out_r <= (ok_d[POLY_LAT-1] && (sin_val <= h_d[POLY_LAT-1])) ?
                  cand_d[POLY_LAT-1] : th_d[POLY_LAT-1];
      h_out_r  <= h_d[POLY_LAT-1];
    end
  end

  assign th_out = th_out_r;
  assign h_out  = h_out_r;

endmodule

// ===== rtl/haversine_distance_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Handshake
// in_ch     in   first_lat, first_lon, second_lat, second_lon   valid / ready
// out_ch    out  distance_cm                                    valid / ready
//
// One transaction per cycle sustained while out_ch is not stalled; a transaction
// enters the first of 547 pipeline stages at the accepting edge, and its result
// passes from the last stage into the output register.
// Latency is set by the arcsine search: 31 bit stages, each running a
// 14-stage sine/cosine polynomial, behind the 31-stage square root.
// Reset (rst_n low, synchronous) clears only the valid bits.
// The whole pipeline holds while a result waits and the last stage is full;
// bubbles are not drained then, and no new transaction is taken during a stall.
module haversine_distance_unit import hdu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hdu_in_if.sink    in_ch,
  hdu_out_if.source out_ch
);

  // Pipeline control
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;
  logic [30:0]           out_dist_r;
  logic                  out_load;

  // Stage 1: angle differences and doubled latitudes, wrapped to one turn
  logic [33:0] lat1_x, lat2_x, lon1_x, lon2_x;
  logic [33:0] ang [4];
  logic [32:0] m_r [4];

  // Stage 2: quadrant and octant fold
  logic [1:0]  qd [4];
  logic [32:0] rq [4];
  logic        fold [4];
  logic [32:0] rf [4];
  logic [29:0] r_r [4];
  logic        sel2_r [4];
  logic        neg2_r [4];

  // Stage 3: conversion to Q0.30 radians
  logic [62:0] xp [4];
  logic [29:0] x_r [4];
  logic        sel3_r [4];
  logic [1:0]  neg3_r;

  // Polynomial results and the cosine signs traveling beside them
  logic [30:0] pres [4];
  logic [1:0]  negd_r [POLY_LAT];

  // Products and the haversine sum
  logic        c1neg, c2neg;
  logic [61:0] sl_p, so_p, cc_p, term_p;
  logic [30:0] sl2_r, so2_r, cc_r;
  logic        xneg1_r;
  logic [30:0] sl2b_r, term_r;
  logic        xneg2_r;
  logic [31:0] a_sum;
  logic [30:0] a_nxt;
  logic [30:0] a_r;

  // Square root, one result bit per stage
  logic [60:0] sq_n_r   [SQRT_STEPS];
  logic [61:0] sq_res_r [SQRT_STEPS];
  logic [30:0] h_val;

  // Arcsine chain
  logic [30:0] th_w [ASIN_BITS+1];
  logic [30:0] h_w  [ASIN_BITS+1];

  // Final scaling
  logic [61:0] dist_p;

  // Advance unless a result is waiting and the last stage holds another one
  assign adv         = out_ch.ready || !out_valid_r || !vld_r[PIPE_DEPTH-1];
  assign in_ch.ready = adv;
  assign out_load    = vld_r[PIPE_DEPTH-1] && (out_ch.ready || !out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Add one turn to negative angles; every input angle is within one turn of zero
  function automatic logic [32:0] wrap_turn(input logic [33:0] a);
    logic [33:0] sum;
    sum = a + {1'b0, TURN_HALF};
    return a[33] ? sum[32:0] : a[32:0];
  endfunction

  assign lat1_x = {{3{in_ch.first_lat[30]}}, in_ch.first_lat};
  assign lat2_x = {{3{in_ch.second_lat[30]}}, in_ch.second_lat};
  assign lon1_x = {{2{in_ch.first_lon[31]}}, in_ch.first_lon};
  assign lon2_x = {{2{in_ch.second_lon[31]}}, in_ch.second_lon};

  // Angles 0 and 1 need the sine, angles 2 and 3 the cosine
  assign ang[0] = lat2_x - lat1_x;
  assign ang[1] = lon2_x - lon1_x;
  assign ang[2] = {lat1_x[32:0], 1'b0};
  assign ang[3] = {lat2_x[32:0], 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        m_r[i] <= wrap_turn(ang[i]);
      end
    end
  end

  // Pick the series from quadrant parity and fold; the sign from the quadrant
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (m_r[i] >= TQUART_HALF) begin
        qd[i] = 2'd3;
        rq[i] = m_r[i] - TQUART_HALF;
      end else if (m_r[i] >= HALF_HALF) begin
        qd[i] = 2'd2;
        rq[i] = m_r[i] - HALF_HALF;
      end else if (m_r[i] >= QUART_HALF) begin
        qd[i] = 2'd1;
        rq[i] = m_r[i] - QUART_HALF;
      end else begin
        qd[i] = 2'd0;
        rq[i] = m_r[i];
      end
      fold[i] = rq[i] > OCT_HALF;
      rf[i]   = fold[i] ? (QUART_HALF - rq[i]) : rq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        r_r[i] <= rf[i][29:0];
        if (i < 2) begin
          sel2_r[i] <= qd[i][0] ^ fold[i];
          neg2_r[i] <= qd[i][1];
        end else begin
          sel2_r[i] <= ~(qd[i][0] ^ fold[i]);
          neg2_r[i] <= qd[i][0] ^ qd[i][1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xp[i] = 63'(r_r[i]) * 63'(RAD_K) + 63'(64'h8000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        x_r[i]    <= 30'(xp[i] >> 32);
        sel3_r[i] <= sel2_r[i];
      end
      neg3_r <= {neg2_r[3], neg2_r[2]};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_trig
    hdu_poly u_poly (
      .clk     (clk),
      .adv     (adv),
      .x       (x_r[i]),
      .sel_cos (sel3_r[i]),
      .res     (pres[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negd_r[0] <= neg3_r;
      for (int k = 1; k < POLY_LAT; k++) begin
        negd_r[k] <= negd_r[k-1];
      end
    end
  end

  // A negated zero stays non-negative
  assign c1neg = negd_r[POLY_LAT-1][0] && (pres[2] != 31'd0);
  assign c2neg = negd_r[POLY_LAT-1][1] && (pres[3] != 31'd0);
  assign sl_p  = pres[0] * pres[0];
  assign so_p  = pres[1] * pres[1];
  assign cc_p  = pres[2] * pres[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      sl2_r   <= 31'(sl_p >> 30);
      so2_r   <= 31'(so_p >> 30);
      cc_r    <= 31'(cc_p >> 30);
      xneg1_r <= c1neg ^ c2neg;
    end
  end

  assign term_p = cc_r * so2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      term_r  <= 31'(term_p >> 30);
      sl2b_r  <= sl2_r;
      xneg2_r <= xneg1_r;
    end
  end

  // Clamp a to [0, 1]
  assign a_sum = {1'b0, sl2b_r} + {1'b0, term_r};

  always_comb begin
    if (xneg2_r) begin
      a_nxt = (term_r > sl2b_r) ? 31'd0 : (sl2b_r - term_r);
    end else begin
      a_nxt = (a_sum > {1'b0, ONE_Q30}) ? ONE_Q30 : a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
    end
  end

  // Integer square root of a * 2^30, digit recurrence from the top bit pair
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [60:0] n_in;
    logic [61:0] res_in;
    logic [61:0] sq_bit;
    logic [61:0] sum;
    logic        ge;
    logic [61:0] n_diff;
    logic [60:0] n_nxt;
    logic [61:0] res_nxt;

    if (k == 0) begin : g_first
      assign n_in   = {a_r, 30'd0};
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = sq_n_r[k-1];
      assign res_in = sq_res_r[k-1];
    end

    assign sq_bit  = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
    assign sum     = res_in + sq_bit;
    assign ge      = {1'b0, n_in} >= sum;
    assign n_diff  = {1'b0, n_in} - sum;
    assign n_nxt   = ge ? n_diff[60:0] : n_in;
    assign res_nxt = ge ? ((res_in >> 1) + sq_bit) : (res_in >> 1);

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n_r[k]   <= n_nxt;
        sq_res_r[k] <= res_nxt;
      end
    end
  end

  assign h_val = (sq_res_r[SQRT_STEPS-1] > 62'(ONE_Q30)) ?
                 ONE_Q30 : sq_res_r[SQRT_STEPS-1][30:0];

  // Arcsine: keep each bit, top down, while sin(theta) stays at or below h
  assign th_w[0] = '0;
  assign h_w[0]  = h_val;

  for (genvar j = 0; j < ASIN_BITS; j++) begin : g_asin
    hdu_asin_bit u_bit (
      .clk      (clk),
      .adv      (adv),
      .bit_mask (31'(1) << (ASIN_BITS - 1 - j)),
      .th_in    (th_w[j]),
      .h_in     (h_w[j]),
      .th_out   (th_w[j+1]),
      .h_out    (h_w[j+1])
    );
  end

  // distance = round(2 * theta * R)
  assign dist_p = {th_w[ASIN_BITS], 1'b0} * RADIUS_CM + 62'(64'h2000_0000);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dist_r <= 31'(dist_p >> 30);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_cm = out_dist_r;

endmodule

// ===== rtl/hdu_checker.sv =====
`timescale 1ns / 1ps
`include "haversine_distance_unit_macros.svh"
module hdu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] distance_cm
);

  `HDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `HDU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(distance_cm))
  `HDU_ASSERT_NOW(a_dist_range, out_valid, distance_cm <= 31'd2001508680)
  `HDU_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `HDU_ASSERT_RST(a_reset_clears, !out_valid)

endmodule

bind haversine_distance_unit hdu_checker u_hdu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .distance_cm (out_ch.distance_cm)
);
